// File: rtl/amgd_pkg.sv
// ----------------------------------------------------------------------------
// amgd_pkg
// Shared sizes, code words, types and grid helpers for the marker grid decoder.
// ----------------------------------------------------------------------------
package amgd_pkg;

	localparam int GridN     = 7;
	localparam int GridCells = GridN * GridN;
	localparam int IdW       = 10;
	localparam int TurnW     = 2;
	localparam int NumLanes  = 4;
	localparam int RowW      = 5;
	localparam int CfgW      = 3;
	localparam int NumWords  = 4;

	localparam logic [CfgW-1:0] BorderFaultsReset = 3'd3;

	// Code words, bit j is column j+1 of the inner row.
	localparam logic [RowW-1:0] CodeWords [NumWords] = '{
		5'b00001,
		5'b11101,
		5'b10010,
		5'b01110
	};

	typedef logic [GridCells-1:0] grid_t;
	typedef logic [TurnW-1:0]     turn_t;
	typedef logic [IdW-1:0]       id_t;

	typedef struct packed {
		logic match;
		id_t  id;
	} lane_res_t;

	typedef struct packed {
		logic valid;
		logic reject;
	} stage_ctl_t;

	// One clockwise quarter turn: new (r,c) takes old (6-c, r).
	function automatic grid_t rot_cw(input grid_t g);
		grid_t t;
		for (int r = 0; r < GridN; r++) begin
			for (int c = 0; c < GridN; c++) begin
				t[r*GridN + c] = g[(GridN - 1 - c)*GridN + r];
			end
		end
		return t;
	endfunction

endpackage

// File: rtl/amgd_screen.sv
// ----------------------------------------------------------------------------
// amgd_screen
// Rejects single-color grids and grids with too many failing border positions.
// ----------------------------------------------------------------------------
module amgd_screen import amgd_pkg::*; (
	input  grid_t            grid,
	input  logic [CfgW-1:0]  faults_allowed,
	output logic             reject
);

	logic [GridN-1:0] fail;
	logic [CfgW-1:0]  bad;
	logic             all_same;

	always_comb begin
		for (int i = 0; i < GridN; i++) begin
			fail[i] = !grid[i*GridN] || !grid[i*GridN + GridN - 1] ||
				!grid[i] || !grid[(GridN - 1)*GridN + i];
		end
	end

	always_comb begin
		bad = '0;
		for (int i = 0; i < GridN; i++) begin
			bad = bad + CfgW'(fail[i]);
		end
	end

	assign all_same = (grid == '0) || (grid == '1);
	assign reject   = all_same || (bad > faults_allowed);

endmodule

// File: rtl/amgd_lane.sv
// ----------------------------------------------------------------------------
// amgd_lane
// One rotation lane: turns the inverted grid, matches inner rows, pulls the id.
// ----------------------------------------------------------------------------
module amgd_lane import amgd_pkg::*; (
	input  logic      clk,
	input  grid_t     grid,
	input  turn_t     turn,
	output lane_res_t res_s2
);

	grid_t         inv;
	grid_t         rg;
	logic [RowW-1:0] row;
	logic          row_ok;
	lane_res_t     res;

	assign inv = ~grid;

	always_comb begin
		unique case (turn)
			2'd0:    rg = inv;
			2'd1:    rg = rot_cw(inv);
			2'd2:    rg = rot_cw(rot_cw(inv));
			2'd3:    rg = rot_cw(rot_cw(rot_cw(inv)));
			default: rg = inv;
		endcase
	end

	always_comb begin
		res.match = 1'b1;
		res.id    = '0;
		row       = '0;
		row_ok    = 1'b0;
		for (int r = 1; r <= RowW; r++) begin
			row    = rg[r*GridN + 1 +: RowW];
			row_ok = 1'b0;
			for (int w = 0; w < NumWords; w++) begin
				row_ok = row_ok || (row == CodeWords[w]);
			end
			res.match = res.match && row_ok;
			// first row lands in the top bits
			res.id[IdW - 2*r + 1] = rg[r*GridN + 2];
			res.id[IdW - 2*r]     = rg[r*GridN + 4];
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= res;
	end

endmodule

// File: rtl/amgd_merge.sv
// ----------------------------------------------------------------------------
// amgd_merge
// Picks the lowest matching rotation and registers the result word.
// ----------------------------------------------------------------------------
module amgd_merge import amgd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  stage_ctl_t ctl_s2,
	input  lane_res_t  lanes_s2 [NumLanes],
	output logic       done,
	output logic       valid_res,
	output id_t        marker_id,
	output turn_t      turns
);

	logic  hit;
	id_t   id_sel;
	turn_t turn_sel;

	always_comb begin
		hit      = 1'b0;
		id_sel   = '0;
		turn_sel = '0;
		for (int k = NumLanes - 1; k >= 0; k--) begin
			if (lanes_s2[k].match) begin
				hit      = 1'b1;
				id_sel   = lanes_s2[k].id;
				turn_sel = TurnW'(k);
			end
		end
		if (ctl_s2.reject || !hit) begin
			hit      = 1'b0;
			id_sel   = '0;
			turn_sel = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		valid_res <= hit;
		marker_id <= id_sel;
		turns     <= turn_sel;
	end

endmodule

// File: rtl/aruco_marker_grid_decoder_unit.sv
// ----------------------------------------------------------------------------
// aruco_marker_grid_decoder_unit
// Decodes one 7x7 binarized grid per cycle as an original 5x5 ArUco marker.
// ----------------------------------------------------------------------------
// The unit takes a new grid on every clock cycle: busy is always low, so any
// cycle with start high delivers a word. Each grid comes out as a single-cycle
// done strobe with valid_res, marker_id and turns; the receiver cannot stall,
// so sample the result on the done cycle. The pipeline has three register
// stages: the color and border screen, the four rotation lanes (one per
// quarter turn, all working at once), and the merge that picks the lowest
// matching turn. Rejected or unmatched grids give valid_res, marker_id and
// turns all zero. border_faults_allowed is written through the cfg channel,
// which is always ready; write it only while idle.
// ----------------------------------------------------------------------------
module aruco_marker_grid_decoder_unit import amgd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  grid_t            grid,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CfgW-1:0]  cfg_data,
	output logic             done,
	output logic             valid_res,
	output id_t              marker_id,
	output turn_t            turns
);

	logic [CfgW-1:0] faults_allowed_q;
	logic            reject;
	grid_t           grid_s1;
	stage_ctl_t      ctl_s1;
	stage_ctl_t      ctl_s2;
	lane_res_t       lanes_s2 [NumLanes];

	// No back pressure anywhere: accept every start.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Hold the fault limit; update on a cfg word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			faults_allowed_q <= BorderFaultsReset;
		end else if (cfg_valid && cfg_ready) begin
			faults_allowed_q <= cfg_data;
		end
	end

	// Screen the raw grid before it enters the pipeline.
	amgd_screen u_screen (
		.grid           (grid),
		.faults_allowed (faults_allowed_q),
		.reject         (reject)
	);

	// Stage 1: capture the grid and the screen verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1.valid  <= start && !busy;
			ctl_s1.reject <= reject;
			ctl_s2        <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		grid_s1 <= grid;
	end

	// Stage 2: one lane per quarter turn, all in parallel.
	for (genvar k = 0; k < NumLanes; k++) begin : g_lane
		amgd_lane u_lane (
			.clk    (clk),
			.grid   (grid_s1),
			.turn   (TurnW'(k)),
			.res_s2 (lanes_s2[k])
		);
	end

	// Stage 3: merge the lanes into the result word.
	amgd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s2    (ctl_s2),
		.lanes_s2  (lanes_s2),
		.done      (done),
		.valid_res (valid_res),
		.marker_id (marker_id),
		.turns     (turns)
	);

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ArUco 5x5 marker grid decoder unit.
// ----------------------------------------------------------------------------
// Drives grid words through the start/busy command port and checks every done
// strobe against a fixed expectation or a grid decoder kept in the bench. The
// directed vectors come first and cover uniform grids, clean markers, border
// faults at the limit and rotated markers. After them come random phases,
// each under its own border fault limit and its own sender idle rate.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import amgd_pkg::*;

	typedef struct packed {
		logic  ok;
		id_t   id;
		turn_t t;
	} decode_t;

	typedef struct {
		grid_t   g;
		bit      typed;
		decode_t want;
	} vector_t;

	// Inner row words, column 1 in the MSB, column 5 in the LSB.
	localparam logic [RowW-1:0] MarkWords [NumWords] = '{
		5'b10000, 5'b10111, 5'b01001, 5'b01110
	};

	localparam int NumPhases   = 6;
	localparam int PhaseItems  = 150;
	localparam int DrainCycles = 6;

	// Border fault limit and sender idle rate (percent) of each random phase.
	localparam logic [CfgW-1:0] PhaseLimit [NumPhases] = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd1, 3'd6};
	localparam int              PhaseIdle  [NumPhases] = '{0, 83, 21, 0, 83, 21};

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic            busy;
	grid_t           grid = '0;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [CfgW-1:0] cfg_data = '0;
	logic            done;
	logic            valid_res;
	id_t             marker_id;
	turn_t           turns;

	// Fixed expectation that travels with a directed word.
	bit              want_typed = 1'b0;
	decode_t         want_res = '0;

	logic [CfgW-1:0] faults_limit = BorderFaultsReset;
	decode_t         expected [$];
	vector_t         vectors [$];
	int              errors = 0;

	aruco_marker_grid_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.grid      (grid),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.valid_res (valid_res),
		.marker_id (marker_id),
		.turns     (turns)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One clockwise quarter turn: new (r,c) takes old (6-c, r).
	function automatic grid_t quarter_turn(grid_t g);
		grid_t t;
		for (int r = 0; r < GridN; r++) begin
			for (int c = 0; c < GridN; c++) begin
				t[r*GridN + c] = g[(GridN - 1 - c)*GridN + r];
			end
		end
		return t;
	endfunction

	// Work out what the unit must report for one grid under a given fault limit.
	function automatic decode_t decode_grid(grid_t g, logic [CfgW-1:0] limit);
		decode_t         res;
		grid_t           inv;
		int              bad;
		logic [RowW-1:0] row;
		logic            hit;
		logic            row_ok;
		res = '0;
		// Reject a grid of a single color outright.
		if (g == '0 || g == '1) begin
			return res;
		end
		bad = 0;
		for (int i = 0; i < GridN; i++) begin
			if (!g[i*GridN] || !g[i*GridN + GridN - 1] || !g[i] || !g[(GridN - 1)*GridN + i]) begin
				bad++;
			end
		end
		if (bad > int'(limit)) begin
			return res;
		end
		inv = ~g;
		for (int k = 0; k < NumLanes; k++) begin
			hit = 1'b1;
			for (int r = 1; r <= RowW; r++) begin
				for (int c = 1; c <= RowW; c++) begin
					row[RowW - c] = inv[r*GridN + c];
				end
				row_ok = 1'b0;
				for (int w = 0; w < NumWords; w++) begin
					if (row == MarkWords[w]) begin
						row_ok = 1'b1;
					end
				end
				hit &= row_ok;
			end
			if (hit) begin
				for (int r = 1; r <= RowW; r++) begin
					res.id = {res.id[IdW-3:0], inv[r*GridN + 2], inv[r*GridN + 4]};
				end
				res.ok = 1'b1;
				res.t  = turn_t'(k);
				return res;
			end
			inv = quarter_turn(inv);
		end
		return res;
	endfunction

	// Build an upright marker: each id digit pair picks the word of one inner row,
	// so an unturned match reads the same id back.
	function automatic grid_t marker_from_id(id_t id);
		grid_t           inv;
		logic [RowW-1:0] w;
		inv = '0;
		for (int r = 1; r <= RowW; r++) begin
			w = MarkWords[id[(IdW - 1 - 2*(r - 1)) -: 2]];
			for (int c = 1; c <= RowW; c++) begin
				inv[r*GridN + c] = w[RowW - c];
			end
		end
		return ~inv;
	endfunction

	// Blacken one border cell at each flagged index position; side picks which one.
	function automatic grid_t blacken_border(grid_t g, logic [GridN-1:0] mask, int side);
		for (int i = 0; i < GridN; i++) begin
			if (mask[i]) begin
				case (side)
					0: begin
						g[i*GridN] = 1'b0;
					end
					1: begin
						g[i*GridN + GridN - 1] = 1'b0;
					end
					2: begin
						g[i] = 1'b0;
					end
					default: begin
						g[(GridN - 1)*GridN + i] = 1'b0;
					end
				endcase
			end
		end
		return g;
	endfunction

	function automatic void add_vector(grid_t g, bit typed, logic ok, id_t id, turn_t t);
		vector_t v;
		v.g    = g;
		v.typed = typed;
		v.want = '{ok: ok, id: id, t: t};
		vectors.push_back(v);
	endfunction

	task automatic flag(string what, int got, int want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	// Present one word and hold it until the unit takes it.
	task automatic send_grid(grid_t g, bit typed, decode_t want);
		grid       <= g;
		start      <= 1'b1;
		want_typed <= typed;
		want_res   <= want;
		do @(posedge clk); while (busy);
	endtask

	// Drop start on each cycle with the given percentage.
	task automatic maybe_idle(int pct);
		while ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop sending and wait until every pending result is out, then let the
	// pipeline settle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (expected.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_limit(logic [CfgW-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Monitor: check a finished word first, then log the word taken at this
	// edge, then track register writes. The unit's latency keeps the two
	// apart, so the oldest expectation always belongs to the strobe.
	always @(posedge clk) begin : monitor
		decode_t exp_res;
		if (arst_n) begin
			if (done) begin
				if (expected.size() == 0) begin
					flag("result with nothing pending, marker_id", int'(marker_id), 0);
				end else begin
					exp_res = expected.pop_front();
					if (valid_res !== exp_res.ok) begin
						flag("valid_res", int'(valid_res), int'(exp_res.ok));
					end
					if (marker_id !== exp_res.id) begin
						flag("marker_id", int'(marker_id), int'(exp_res.id));
					end
					if (turns !== exp_res.t) begin
						flag("turns", int'(turns), int'(exp_res.t));
					end
				end
			end
			if (start && !busy) begin
				expected.push_back(want_typed ? want_res : decode_grid(grid, faults_limit));
			end
			if (cfg_valid && cfg_ready) begin
				faults_limit <= cfg_data;
			end
		end
	end

	initial begin : stimulus
		grid_t   g;
		grid_t   m;
		decode_t none;
		int      sel;
		none = '0;

		// Uniform grids, an all-black border and grids with one black corner are rejected.
		add_vector('0, 1, 1'b0, '0, '0);
		add_vector('1, 1, 1'b0, '0, '0);
		add_vector(grid_t'(1) << 24, 1, 1'b0, '0, '0);
		add_vector(~(grid_t'(1) << 48), 0, 1'b0, '0, '0);
		add_vector(~(grid_t'(1) << 0), 0, 1'b0, '0, '0);
		// Clean upright markers read their id back with no turn.
		add_vector(marker_from_id('0), 1, 1'b1, '0, '0);
		add_vector(marker_from_id('1), 1, 1'b1, '1, '0);
		add_vector(marker_from_id(10'h1B4), 1, 1'b1, 10'h1B4, '0);
		// Turned markers: let the decoder pick the lowest matching turn.
		m = marker_from_id(10'h2C9);
		add_vector(quarter_turn(m), 0, 1'b0, '0, '0);
		add_vector(quarter_turn(quarter_turn(m)), 0, 1'b0, '0, '0);
		add_vector(quarter_turn(quarter_turn(quarter_turn(m))), 0, 1'b0, '0, '0);
		m = marker_from_id(10'h0E1);
		add_vector(quarter_turn(m), 0, 1'b0, '0, '0);
		// Border faults right at the reset limit, one over, and all positions.
		add_vector(blacken_border(marker_from_id(10'h0F0), 7'b0000111, 0), 1,
			1'b1, 10'h0F0, '0);
		add_vector(blacken_border(marker_from_id(10'h0F0), 7'b1001011, 2), 1,
			1'b0, '0, '0);
		add_vector(blacken_border(marker_from_id(10'h0F0), 7'b1111111, 3), 1,
			1'b0, '0, '0);
		add_vector(blacken_border(marker_from_id(10'h333), 7'b1100001, 1), 0,
			1'b0, '0, '0);
		// One bad inner cell, and patterns that fit no word.
		add_vector(marker_from_id(10'h155) ^ (grid_t'(1) << 17), 0, 1'b0, '0, '0);
		add_vector(grid_t'(64'h5555_5555_5555_5555), 0, 1'b0, '0, '0);
		add_vector(grid_t'(64'hAAAA_AAAA_AAAA_AAAA), 0, 1'b0, '0, '0);
		add_vector(~marker_from_id(10'h2AA), 0, 1'b0, '0, '0);

		// Hold reset, then release it once and for all.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset limit, back to back.
		foreach (vectors[i]) begin
			send_grid(vectors[i].g, vectors[i].typed, vectors[i].want);
		end

		for (int p = 0; p < NumPhases; p++) begin
			write_limit(PhaseLimit[p]);
			for (int n = 0; n < PhaseItems; n++) begin
				maybe_idle(PhaseIdle[p]);
				sel = $urandom_range(0, 99);
				g = marker_from_id(id_t'($urandom_range(0, 1023)));
				if (sel < 55) begin
					// Well-formed marker, turned at random, mostly with some border damage.
					repeat ($urandom_range(0, 3)) g = quarter_turn(g);
					if ($urandom_range(0, 3) != 0) begin
						g = blacken_border(g, GridN'($urandom) & GridN'($urandom),
							$urandom_range(0, 3));
					end
				end else if (sel < 75) begin
					// Marker with one or two cells flipped anywhere.
					g[$urandom_range(0, GridCells - 1)] ^= 1'b1;
					if ($urandom_range(0, 1) != 0) begin
						g[$urandom_range(0, GridCells - 1)] ^= 1'b1;
					end
				end else if (sel < 92) begin
					g = grid_t'({$urandom, $urandom});
				end else begin
					// Near-uniform grids around the single-color check.
					g = ($urandom_range(0, 1) != 0) ? '1 : '0;
					if ($urandom_range(0, 1) != 0) begin
						g[$urandom_range(0, GridCells - 1)] ^= 1'b1;
					end
				end
				send_grid(g, 1'b0, none);
			end
		end

		drain();
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
